/* rtl/p2g_pkg.sv */
// Shared types and constants for the pixel-to-glyph mapper.
`timescale 1ns / 1ps
package p2g_pkg;

  // Field widths fixed by the interface
  localparam int unsigned PIXW  = 8;   // color and alpha components
  localparam int unsigned SYMW  = 8;   // glyph / symbol code
  localparam int unsigned LVLW  = 6;   // level field of a load word
  localparam int unsigned IWW   = 13;  // image width register
  localparam int unsigned SUMW  = 15;  // 30*r + 59*g + 11*b < 2^15
  localparam int unsigned DIVW  = 23;  // luma divisor width
  localparam int unsigned CFGIW = 1;   // register index width
  localparam int unsigned CFGDW = 13;  // register data width

  // Luma weights and divisor (100 * 255 * 255)
  localparam logic [SUMW-1:0] WT_RED   = SUMW'(30);
  localparam logic [SUMW-1:0] WT_GREEN = SUMW'(59);
  localparam logic [SUMW-1:0] WT_BLUE  = SUMW'(11);
  localparam logic [DIVW-1:0] LUMA_DIV = DIVW'(6502500);

  // Divide by LUMA_DIV as a multiply by ceil(2^54 / LUMA_DIV) and a shift;
  // exact for every product below 2^31
  localparam int unsigned     RCPW       = 32;
  localparam int unsigned     LUMA_SHIFT = 54;
  localparam logic [RCPW-1:0] LUMA_RECIP = 32'd2770380394;

  // Alpha used when the image carries no alpha channel
  localparam logic [PIXW-1:0] ALPHA_OPAQUE = 8'hFF;

  // Symbol emitted at the start of a skipped row
  localparam logic [SYMW-1:0] NEWLINE_CODE = 8'd10;

  // Level search groups levels in blocks of eight
  localparam int unsigned GRP  = 8;
  localparam int unsigned GRPW = 3;

  // Word kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_PIXEL = 1'b1;

  // Register indexes
  localparam logic [CFGIW-1:0] REG_IMAGE_WIDTH   = 1'b0;
  localparam logic [CFGIW-1:0] REG_ALPHA_PRESENT = 1'b1;

  // Top-level sequencer
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_LUMA  = 6'b000010,
    ST_SRCH1 = 6'b000100,
    ST_SRCH2 = 6'b001000,
    ST_READ  = 6'b010000,
    ST_EMIT  = 6'b100000
  } ctl_state_t;

  // Luma unit sequencer
  typedef enum logic [3:0] {
    LS_IDLE  = 4'b0001,
    LS_MUL1  = 4'b0010,
    LS_MUL2  = 4'b0100,
    LS_SCALE = 4'b1000
  } luma_state_t;

endpackage

/* rtl/p2g_luma.sv */
// Luma level unit: weighted sum times top level times alpha, scaled by 1/(100*255*255).
`timescale 1ns / 1ps
module p2g_luma import p2g_pkg::*; #(
  parameter int unsigned LW = 6
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [SUMW-1:0] sum,
  input  logic [PIXW-1:0] alpha,
  input  logic [LW-1:0]   top,     // held stable by the caller while busy
  output logic            done,
  output logic [LW-1:0]   idx
);

  localparam int unsigned P1W = SUMW + LW;
  localparam int unsigned PW  = SUMW + LW + PIXW;
  localparam int unsigned SW  = PW + RCPW;

  luma_state_t      state_r, state_nxt;
  logic [SUMW-1:0]  sum_r;
  logic [PIXW-1:0]  alpha_r;
  logic [P1W-1:0]   prod1_r;
  logic [PW-1:0]    prod2_r;
  logic [SW-1:0]    scaled;
  logic [LW-1:0]    q_r;
  logic             done_r;

  assign scaled = SW'(prod2_r) * SW'(LUMA_RECIP);
  assign done   = done_r;
  assign idx    = q_r;

  // Sequence: capture, two multiplies, then the reciprocal multiply
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      LS_IDLE:  if (start) state_nxt = LS_MUL1;
      LS_MUL1:  state_nxt = LS_MUL2;
      LS_MUL2:  state_nxt = LS_SCALE;
      LS_SCALE: state_nxt = LS_IDLE;
      default:  state_nxt = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LS_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == LS_SCALE);
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      LS_IDLE: begin
        if (start) begin
          sum_r   <= sum;
          alpha_r <= alpha;
        end
      end
      LS_MUL1: begin
        prod1_r <= P1W'(sum_r) * P1W'(top);
      end
      LS_MUL2: begin
        prod2_r <= PW'(prod1_r) * PW'(alpha_r);
      end
      LS_SCALE: begin
        // quotient never exceeds top, so LW bits hold it
        q_r <= scaled[LUMA_SHIFT +: LW];
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

endmodule

/* rtl/pixel_to_glyph_mapper_top.sv */
// Pixel-to-glyph mapper: glyph table, raster position and result sequencing.
`timescale 1ns / 1ps
// Usage:
//   The in_ channel carries two kinds of word. A load word (in_kind = 0)
//   stores in_glyph for table level in_level; a pixel word (in_kind = 1)
//   maps in_red/green/blue/alpha to the glyph of the largest loaded level
//   not above its scaled luma, else of the lowest loaded level. Odd rows
//   are skipped: their first pixel yields a newline code, the rest yield
//   nothing. The out_ channel carries out_symbol and out_table_empty.
//   cfg_ writes image_width and alpha_present; cfg_ready is always high.
//   Writes must go only while idle; the block itself does not enforce it.
//   Timing: a load or a skipped pixel does not raise in_stall. A newline or
//   empty-table pixel goes to the emit state; out_valid rises once the
//   output register is free. A drawn pixel passes two operand multiplies,
//   the reciprocal multiply for the divide by 100*255*255, the done
//   handoff, two search steps, the glyph memory read and the pending result
//   load. One word is in flight at a time; in_stall is high while it is.
//   A finished result sits in the output register; while out_stall holds
//   it, the next word is still accepted and runs up to its own result.
//   Synchronous reset empties the table, clears position and output valid,
//   and sets image_width to 1 and alpha_present to 1.
module pixel_to_glyph_mapper_top import p2g_pkg::*; #(
  parameter int unsigned LEVELS    = 64,
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  // input words
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             in_kind,
  input  logic [LVLW-1:0]  in_level,
  input  logic [SYMW-1:0]  in_glyph,
  input  logic [PIXW-1:0]  in_red,
  input  logic [PIXW-1:0]  in_green,
  input  logic [PIXW-1:0]  in_blue,
  input  logic [PIXW-1:0]  in_alpha,
  input  logic             in_frame_start,
  // result words
  output logic             out_valid,
  input  logic             out_stall,
  output logic [SYMW-1:0]  out_symbol,
  output logic             out_table_empty,
  // register writes
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFGIW-1:0] cfg_index,
  input  logic [CFGDW-1:0] cfg_data
);

  localparam int unsigned LW   = $clog2(LEVELS);
  localparam int unsigned XW   = ((LW > LVLW) ? LW : LVLW) + 1;
  localparam int unsigned NG   = (LEVELS + GRP - 1) / GRP;
  localparam int unsigned PADN = NG * GRP;
  localparam int unsigned CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned MWW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW   = (MWW > IWW) ? MWW : IWW;

  ctl_state_t        state_r, state_nxt;

  // configuration
  logic [IWW-1:0]    image_width_r;
  logic              alpha_present_r;

  // table bookkeeping
  logic [LEVELS-1:0] present_r;
  logic [LW-1:0]     top_r;
  logic [LW-1:0]     low_r;
  logic              any_r;
  logic [SYMW-1:0]   glyph_mem [LEVELS];
  logic [SYMW-1:0]   rd_data_r;

  // raster position
  logic [CW-1:0]     column_r, column_nxt;
  logic              odd_r, odd_nxt;

  // pending result and output register
  logic [SYMW-1:0]   pend_sym_r;
  logic              pend_empty_r;
  logic              out_valid_r;
  logic [SYMW-1:0]   out_symbol_r;
  logic              out_empty_r;

  // search tree stage
  logic              hit_r [NG];
  logic [GRPW-1:0]   pos_r [NG];
  logic              hit_c [NG];
  logic [GRPW-1:0]   pos_c [NG];
  logic [PADN-1:0]   pres_pad;
  logic [LW-1:0]     sel_lvl;

  // luma unit hookup
  logic              luma_start;
  logic              luma_done;
  logic [LW-1:0]     luma_idx;
  logic [SUMW-1:0]   sum_c;
  logic [PIXW-1:0]   alpha_c;

  // accept decode
  logic              in_acc, ld_acc, px_acc, ld_ok;
  logic [XW-1:0]     level_x;
  logic [LW-1:0]     ld_lvl;
  logic [CW-1:0]     col0;
  logic              odd0;
  logic              emit_nl, emit_empty, draw;
  logic [WW-1:0]     w_eff;
  logic              row_end;
  logic              out_free;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign ld_acc     = in_acc && (in_kind == KIND_LOAD);
  assign px_acc     = in_acc && (in_kind == KIND_PIXEL);
  assign level_x    = XW'(in_level);
  assign ld_ok      = ld_acc && (level_x < XW'(LEVELS));
  assign ld_lvl     = level_x[LW-1:0];
  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_symbol      = out_symbol_r;
  assign out_table_empty = out_empty_r;

  // Classify a pixel against the position it lands on
  assign col0       = in_frame_start ? '0 : column_r;
  assign odd0       = in_frame_start ? 1'b0 : odd_r;
  assign emit_nl    = odd0 && (col0 == '0);
  assign emit_empty = !odd0 && !any_r;
  assign draw       = !odd0 && any_r;
  assign luma_start = px_acc && draw;

  // Effective row width, clamped to one..MAX_WIDTH
  always_comb begin
    w_eff = WW'(image_width_r);
    if (w_eff == '0) w_eff = WW'(1);
    if (w_eff > WW'(MAX_WIDTH)) w_eff = WW'(MAX_WIDTH);
    row_end = (WW'(col0) + WW'(1)) >= w_eff;
  end

  // Advance the raster position on each pixel
  always_comb begin
    column_nxt = column_r;
    odd_nxt    = odd_r;
    if (px_acc) begin
      if (row_end) begin
        column_nxt = '0;
        odd_nxt    = !odd0;
      end else begin
        column_nxt = col0 + CW'(1);
        odd_nxt    = odd0;
      end
    end
  end

  // Luma operands
  assign sum_c   = WT_RED * SUMW'(in_red) + WT_GREEN * SUMW'(in_green)
                 + WT_BLUE * SUMW'(in_blue);
  assign alpha_c = alpha_present_r ? in_alpha : ALPHA_OPAQUE;

  p2g_luma #(
    .LW(LW)
  ) u_luma (
    .clk   (clk),
    .rst_n (rst_n),
    .start (luma_start),
    .sum   (sum_c),
    .alpha (alpha_c),
    .top   (top_r),
    .done  (luma_done),
    .idx   (luma_idx)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (px_acc) begin
          if (emit_nl || emit_empty) state_nxt = ST_EMIT;
          else if (draw)             state_nxt = ST_LUMA;
        end
      end
      ST_LUMA:  if (luma_done) state_nxt = ST_SRCH1;
      ST_SRCH1: state_nxt = ST_SRCH2;
      ST_SRCH2: state_nxt = ST_READ;
      ST_READ:  state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and table flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      image_width_r   <= IWW'(1);
      alpha_present_r <= 1'b1;
      present_r       <= '0;
      top_r           <= '0;
      low_r           <= '0;
      any_r           <= 1'b0;
      column_r        <= '0;
      odd_r           <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      column_r <= column_nxt;
      odd_r    <= odd_nxt;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[IWW-1:0];
          REG_ALPHA_PRESENT: alpha_present_r <= cfg_data[0];
          default:           alpha_present_r <= alpha_present_r;
        endcase
      end

      // mark a level loaded, track the highest and lowest loaded levels
      if (ld_ok) begin
        present_r[ld_lvl] <= 1'b1;
        any_r             <= 1'b1;
        if (!any_r || (ld_lvl > top_r)) top_r <= ld_lvl;
        if (!any_r || (ld_lvl < low_r)) low_r <= ld_lvl;
      end

      // output register: fill from the pending result, drop when taken
      if ((state_r == ST_EMIT) && out_free) out_valid_r <= 1'b1;
      else if (!out_stall)                  out_valid_r <= 1'b0;
    end
  end

  // Glyph memory: write on load, registered read of the selected level
  always_ff @(posedge clk) begin
    if (ld_ok) glyph_mem[ld_lvl] <= in_glyph;
    if (state_r == ST_SRCH2) rd_data_r <= glyph_mem[sel_lvl];
  end

  // Search stage one: per group, the highest loaded level not above the index
  assign pres_pad = PADN'(present_r);

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      hit_c[g] = 1'b0;
      pos_c[g] = '0;
      for (int b = 0; b < GRP; b++) begin
        if (pres_pad[g*GRP + b] && ((g*GRP + b) <= int'(luma_idx))) begin
          hit_c[g] = 1'b1;
          pos_c[g] = GRPW'(b);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_SRCH1) begin
      for (int g = 0; g < NG; g++) begin
        hit_r[g] <= hit_c[g];
        pos_r[g] <= pos_c[g];
      end
    end
  end

  // Search stage two: highest hitting group, else the lowest loaded level
  always_comb begin
    sel_lvl = low_r;
    for (int g = 0; g < NG; g++) begin
      if (hit_r[g]) sel_lvl = LW'(g*GRP + int'(pos_r[g]));
    end
  end

  // Pending result: immediate codes at accept, glyph after the read
  always_ff @(posedge clk) begin
    if (px_acc) begin
      pend_sym_r   <= emit_nl ? NEWLINE_CODE : '0;
      pend_empty_r <= emit_empty;
    end else if (state_r == ST_READ) begin
      pend_sym_r   <= rd_data_r;
      pend_empty_r <= 1'b0;
    end
    if ((state_r == ST_EMIT) && out_free) begin
      out_symbol_r <= pend_sym_r;
      out_empty_r  <= pend_empty_r;
    end
  end

endmodule

/* rtl/p2g_checker.sv */
// Port-level checks for the pixel-to-glyph mapper, bound to the top level.
`timescale 1ns / 1ps
module p2g_checker import p2g_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            in_kind,
  input logic            out_valid,
  input logic            out_stall,
  input logic [SYMW-1:0] out_symbol,
  input logic            out_table_empty
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // A held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_symbol) && $stable(out_table_empty))
    else $error("stalled result changed");

  // An empty-table result carries symbol zero
  a_empty_symbol: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_empty |-> out_symbol == '0)
    else $error("empty-table result with nonzero symbol");

  // A load does not raise the input stall
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind == KIND_LOAD) |=> !in_stall)
    else $error("input stalled after a load");

  // Only an accepted pixel can raise the input stall
  a_stall_from_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall && !(in_valid && (in_kind == KIND_PIXEL)) |=> !in_stall)
    else $error("input stalled without a pixel");

endmodule

bind pixel_to_glyph_mapper_top p2g_checker u_p2g_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_kind         (in_kind),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_symbol      (out_symbol),
  .out_table_empty (out_table_empty)
);

/* sim/pixel_to_glyph_mapper_top_test.sv */
// Self-checking testbench for the pixel-to-glyph mapper: scoreboard, drivers and stimulus.
`timescale 1ns / 1ps
module pixel_to_glyph_mapper_top_test;
  import p2g_pkg::*;

  localparam int unsigned N_LEVELS      = 64;
  localparam int unsigned MAX_W         = 4096;
  localparam int unsigned LONG_HOLD     = 300;
  localparam int unsigned SETTLE_CYCLES = 24;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int unsigned MAX_REPORTS   = 200;
  localparam int unsigned PHASE_WORDS   = 90;
  localparam int unsigned N_PHASES      = 9;

  typedef struct packed {
    logic            kind;
    logic [LVLW-1:0] level;
    logic [SYMW-1:0] glyph;
    logic [PIXW-1:0] red;
    logic [PIXW-1:0] green;
    logic [PIXW-1:0] blue;
    logic [PIXW-1:0] alpha;
    logic            frame_start;
  } pix_word_t;

  typedef struct packed {
    logic [SYMW-1:0] symbol;
    logic            table_empty;
  } glyph_result_t;

  // Track the glyph table and raster position, queue the symbols they produce
  class glyph_scoreboard;
    bit                    loaded [N_LEVELS];
    logic [SYMW-1:0]       glyph_of [N_LEVELS];
    int unsigned           loaded_cnt;
    int unsigned           top_lvl;
    int unsigned           col;
    bit                    odd;
    int unsigned           width_reg;
    bit                    alpha_on;
    glyph_result_t         symbol_q[$];
    int unsigned           errors;
    int unsigned           words;
    int unsigned           loads;
    int unsigned           glyphs;
    int unsigned           newlines;
    int unsigned           empties;

    function new();
      loaded_cnt = 0;
      top_lvl    = 0;
      col        = 0;
      odd        = 1'b0;
      width_reg  = 1;
      alpha_on   = 1'b1;
      foreach (loaded[l]) loaded[l] = 1'b0;
    endfunction

    function void write_reg(logic [CFGIW-1:0] idx, logic [CFGDW-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == REG_ALPHA_PRESENT) alpha_on = data[0];
    endfunction

    function int pending();
      return symbol_q.size();
    endfunction

    // Append one predicted result word
    function void add_expected(glyph_result_t r);
      symbol_q.insert(symbol_q.size(), r);
    endfunction

    // Predict the result of one accepted input word
    function void note_word(pix_word_t w);
      logic [63:0]   luma;
      logic [63:0]   idx;
      logic [63:0]   a;
      int            l;
      int unsigned   eff_w;
      bit            found;
      glyph_result_t r;
      words++;
      if (w.kind == KIND_LOAD) begin
        loads++;
        if (w.level < N_LEVELS) begin
          if (loaded_cnt == 0 || w.level > top_lvl) top_lvl = w.level;
          if (!loaded[w.level]) loaded_cnt++;
          loaded[w.level]   = 1'b1;
          glyph_of[w.level] = w.glyph;
        end
        return;
      end

      if (w.frame_start) begin
        col = 0;
        odd = 1'b0;
      end

      if (odd) begin
        // first pixel of a skipped row closes the text line
        if (col == 0) begin
          r.symbol      = NEWLINE_CODE;
          r.table_empty = 1'b0;
          add_expected(r);
          newlines++;
        end
      end else if (loaded_cnt == 0) begin
        r.symbol      = '0;
        r.table_empty = 1'b1;
        add_expected(r);
        empties++;
      end else begin
        a    = alpha_on ? 64'(w.alpha) : 64'(ALPHA_OPAQUE);
        luma = 64'(WT_RED) * 64'(w.red) + 64'(WT_GREEN) * 64'(w.green)
             + 64'(WT_BLUE) * 64'(w.blue);
        idx  = (luma * 64'(top_lvl) * a) / 64'(LUMA_DIV);
        if (idx > 64'(top_lvl)) idx = 64'(top_lvl);
        // search down for a loaded level, else take the lowest one
        found    = 1'b0;
        r.symbol = '0;
        for (l = int'(idx); l >= 0 && !found; l--) begin
          if (loaded[l]) begin
            r.symbol = glyph_of[l];
            found    = 1'b1;
          end
        end
        for (l = 0; l < N_LEVELS && !found; l++) begin
          if (loaded[l]) begin
            r.symbol = glyph_of[l];
            found    = 1'b1;
          end
        end
        r.table_empty = 1'b0;
        add_expected(r);
        glyphs++;
      end

      // advance the raster position
      eff_w = width_reg;
      if (eff_w == 0) eff_w = 1;
      if (eff_w > MAX_W) eff_w = MAX_W;
      if (col + 1 >= eff_w) begin
        col = 0;
        odd = !odd;
      end else begin
        col++;
      end
    endfunction

    // Compare one result word against the oldest prediction
    function void check_result(logic [SYMW-1:0] sym, logic empty);
      glyph_result_t e;
      if (symbol_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result: expected none, actual symbol %0d empty %0d",
                   $time, sym, empty);
        return;
      end
      e = symbol_q.pop_front();
      if (sym !== e.symbol || empty !== e.table_empty) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: mismatch: expected sym %0d empty %0d, actual sym %0d empty %0d",
                   $time, e.symbol, e.table_empty, sym, empty);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_kind;
  logic [LVLW-1:0]  in_level;
  logic [SYMW-1:0]  in_glyph;
  logic [PIXW-1:0]  in_red;
  logic [PIXW-1:0]  in_green;
  logic [PIXW-1:0]  in_blue;
  logic [PIXW-1:0]  in_alpha;
  logic             in_frame_start;
  logic             out_valid;
  logic             out_stall;
  logic [SYMW-1:0]  out_symbol;
  logic             out_table_empty;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFGIW-1:0] cfg_index;
  logic [CFGDW-1:0] cfg_data;

  glyph_scoreboard sb = new();
  bit              hold_req = 1'b0;
  bit              no_idle  = 1'b0;
  int unsigned     gap_weight = 0;
  int unsigned     settings = 0;

  pixel_to_glyph_mapper_top #(
    .LEVELS    (N_LEVELS),
    .MAX_WIDTH (MAX_W)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_level        (in_level),
    .in_glyph        (in_glyph),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .in_alpha        (in_alpha),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_symbol      (out_symbol),
    .out_table_empty (out_table_empty),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Observe every handshake at the clock edge
  always @(posedge clk) begin : monitor
    pix_word_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_symbol, out_table_empty);
      if (in_valid && !in_stall) begin
        seen = {in_kind, in_level, in_glyph, in_red, in_green, in_blue, in_alpha,
                in_frame_start};
        sb.note_word(seen);
      end
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // Receiver: random stall bursts, one long hold on request
  initial begin : receiver
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 19);
        repeat (n) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
        repeat (n) @(posedge clk);
      end
    end
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input pix_word_t w);
    in_valid       <= 1'b1;
    in_kind        <= w.kind;
    in_level       <= w.level;
    in_glyph       <= w.glyph;
    in_red         <= w.red;
    in_green       <= w.green;
    in_blue        <= w.blue;
    in_alpha       <= w.alpha;
    in_frame_start <= w.frame_start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_load(input int unsigned level, input int unsigned glyph, input bit fs);
    send_word({KIND_LOAD, LVLW'(level), SYMW'(glyph), PIXW'($urandom), PIXW'($urandom),
               PIXW'($urandom), PIXW'($urandom), fs});
  endtask

  task automatic send_pixel(input int unsigned r, input int unsigned g, input int unsigned b,
                            input int unsigned a, input bit fs);
    send_word({KIND_PIXEL, LVLW'($urandom), SYMW'($urandom), PIXW'(r), PIXW'(g), PIXW'(b),
               PIXW'(a), fs});
  endtask

  task automatic idle_gap(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Hold off until every predicted word is out and the block is quiet
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFGIW-1:0] idx, input logic [CFGDW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic configure(input int unsigned width, input bit alpha_on);
    logic [CFGDW-1:0] d;
    d    = CFGDW'($urandom);
    d[0] = alpha_on;
    put_reg(REG_IMAGE_WIDTH, CFGDW'(width));
    put_reg(REG_ALPHA_PRESENT, d);
    cfg_valid <= 1'b0;
    settings++;
  endtask

  // Bias color components toward their extremes now and then
  function automatic logic [PIXW-1:0] pick_component();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return PIXW'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_word_t make_word(input bit image_start);
    pix_word_t w;
    w.kind        = (!image_start && $urandom_range(0, 99) < 12) ? KIND_LOAD : KIND_PIXEL;
    w.level       = LVLW'($urandom_range(0, N_LEVELS - 1));
    w.glyph       = SYMW'($urandom_range(0, 255));
    w.red         = pick_component();
    w.green       = pick_component();
    w.blue        = pick_component();
    w.alpha       = pick_component();
    w.frame_start = image_start || ($urandom_range(0, 39) == 0);
    return w;
  endfunction

  initial begin : stimulus
    int          phase;
    int          i;
    int          waited;
    int unsigned width;
    bit          alpha_on;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= KIND_LOAD;
    in_level       <= '0;
    in_glyph       <= '0;
    in_red         <= '0;
    in_green       <= '0;
    in_blue        <= '0;
    in_alpha       <= '0;
    in_frame_start <= 1'b0;
    cfg_valid      <= 1'b0;
    cfg_index      <= REG_IMAGE_WIDTH;
    cfg_data       <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, fallback to lowest level, newline and dropped pixels
    configure(4, 1'b1);
    send_pixel(0, 0, 0, 0, 1'b1);
    send_pixel(255, 255, 255, 255, 1'b0);
    send_load(20, 8'h42, 1'b0);
    send_load(5, 8'h41, 1'b1);
    send_pixel(0, 0, 0, 255, 1'b0);
    send_pixel(255, 255, 255, 255, 1'b0);
    send_pixel(255, 255, 255, 255, 1'b0);
    send_pixel(10, 20, 30, 40, 1'b0);
    send_pixel(0, 0, 0, 0, 1'b0);
    send_pixel(0, 0, 0, 0, 1'b0);
    send_pixel(128, 128, 128, 255, 1'b0);
    send_pixel(255, 255, 255, 255, 1'b1);
    // overwrite a level, add the top and bottom levels
    send_load(5, 8'h61, 1'b0);
    send_load(63, 8'hFF, 1'b0);
    send_load(0, 8'h2E, 1'b1);
    send_pixel(255, 0, 0, 255, 1'b0);
    send_pixel(0, 255, 0, 255, 1'b0);
    send_pixel(0, 0, 255, 255, 1'b0);
    send_pixel(255, 255, 255, 255, 1'b0);
    send_pixel(255, 255, 255, 0, 1'b0);
    drain();
    // width zero behaves as one, alpha field ignored
    configure(0, 1'b0);
    send_pixel(255, 255, 255, 0, 1'b1);
    send_pixel(255, 255, 255, 0, 1'b0);
    send_pixel(128, 64, 32, 0, 1'b0);
    drain();

    // Random phases over a range of widths and alpha modes
    for (phase = 0; phase < N_PHASES; phase++) begin
      case (phase)
        0:       begin width = 1;    alpha_on = 1'b1; end
        1:       begin width = 2;    alpha_on = 1'b0; end
        2:       begin width = 3;    alpha_on = 1'b1; end
        3:       begin width = 5;    alpha_on = 1'b0; end
        4:       begin width = 8;    alpha_on = 1'b1; end
        5:       begin width = 0;    alpha_on = 1'b1; end
        6:       begin width = MAX_W; alpha_on = 1'b0; end
        7:       begin width = 8191; alpha_on = 1'b1; end
        default: begin
          width    = $urandom_range(1, 12);
          alpha_on = $urandom_range(0, 1);
        end
      endcase
      if (phase == N_PHASES - 1) no_idle = 1'b1;
      configure(width, alpha_on);
      gap_weight = phase % 4;
      for (i = 0; i < PHASE_WORDS; i++) begin
        // keep offering words while the receiver holds off
        if (phase == 2 && i == PHASE_WORDS / 2) begin
          hold_req = 1'b1;
          while (hold_req) send_word(make_word(1'b0));
        end
        send_word(make_word(i == 0));
        if (!no_idle && $urandom_range(0, 7) < gap_weight) idle_gap($urandom_range(1, 19));
      end
      if (phase != N_PHASES - 1) drain();
    end

    // Wait for the tail, then report
    in_valid <= 1'b0;
    @(posedge clk);
    for (waited = 0; waited < DRAIN_LIMIT && sb.pending() != 0; waited++) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected result words never arrived", $time, sb.pending());
      sb.errors++;
    end
    $display("Run covered %0d input words (%0d table loads) across %0d register settings",
             sb.words, sb.loads, settings);
    $display("Results seen: %0d glyphs, %0d newlines, %0d empty-table flags; %0d errors",
             sb.glyphs, sb.newlines, sb.empties, sb.errors);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog on the whole run
  initial begin : watchdog
    #5000000;
    $display("%0t: run timed out", $time);
    $display("*** FAILED ***");
    $finish;
  end

endmodule
